// File: rtl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DLTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define DLTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/dlts_pkg.sv
// shared types, sizes and codes of the delta-list timer scheduler
`timescale 1ns / 1ps
package dlts_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] FN_TICK     = 2'd0;
  localparam logic [1:0] FN_ADD      = 2'd1;
  localparam logic [1:0] FN_DELETE   = 2'd2;
  localparam logic [1:0] FN_DISPATCH = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  task_handle;
    logic [31:0] delay;
    logic [31:0] period;
    logic [31:0] task_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_id;
    logic [7:0]  run_handle;
    logic        head_ready;
  } res_t;

  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] delta;
    logic [31:0] period;
    logic [31:0] ident;
    logic        ready;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } stat_t;

endpackage

// File: rtl/dlts_ram.sv
// generic simple dual-port ram with registered read data
`timescale 1ns / 1ps
module dlts_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/dlts_ctrl.sv
// sequencer that walks, shifts and updates the entry memory
`timescale 1ns / 1ps
module dlts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  dlts_pkg::cmd_t    cmd_i,
  output dlts_pkg::stat_t   stat_o,
  output dlts_pkg::res_t    res_o,
  output dlts_pkg::ram_req_t ram_req_o,
  input  dlts_pkg::entry_t  ram_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_ADD_RD,
    S_ADD_CHK,
    S_SUP_RD,
    S_SUP_WR,
    S_ADD_WR,
    S_DEL_RD,
    S_DEL_CHK,
    S_DSP,
    S_SDN_RD,
    S_SDN_WR
  } state_e;

  state_e                        state_q, state_d;
  logic [dlts_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          head_rdy_q, head_rdy_d;
  logic [31:0]                   nid_q, nid_d;
  logic                          done_q, done_d;
  dlts_pkg::res_t                res_q, res_d;

  logic [dlts_pkg::CNT_W-1:0]    idx_q, idx_d;
  logic [dlts_pkg::IDX_W-1:0]    ins_q, ins_d;
  logic [31:0]                   sum_q, sum_d;
  logic [31:0]                   trim_q, trim_d;
  logic [31:0]                   del_q, del_d;
  logic [7:0]                    handle_q, handle_d;
  logic [31:0]                   delay_q, delay_d;
  logic [31:0]                   period_q, period_d;
  logic [31:0]                   tid_q, tid_d;
  logic [7:0]                    run_q, run_d;
  logic                          redo_q, redo_d;

  logic [32:0]                   tot;
  logic [32:0]                   fold;
  logic [31:0]                   fold_sat;
  logic [31:0]                   nid_inc;
  logic [31:0]                   fresh;
  logic [31:0]                   nd;
  logic [31:0]                   dec;
  logic                          fin;
  logic [1:0]                    fin_status;
  logic [31:0]                   fin_rid;
  dlts_pkg::ram_req_t            req;

  assign tot      = {1'b0, sum_q} + {1'b0, ram_rdata_i.delta};
  assign fold     = {1'b0, ram_rdata_i.delta} + {1'b0, del_q};
  assign fold_sat = fold[32] ? '1 : fold[31:0];
  assign nid_inc  = nid_q + 32'd1;
  assign fresh    = (nid_inc == '0) ? 32'd1 : nid_inc;
  assign nd       = delay_q - sum_q;
  assign dec      = (ram_rdata_i.delta != '0) ? ram_rdata_i.delta - 32'd1 : '0;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    head_rdy_d = head_rdy_q;
    nid_d      = nid_q;
    done_d     = 1'b0;
    res_d      = res_q;
    idx_d      = idx_q;
    ins_d      = ins_q;
    sum_d      = sum_q;
    trim_d     = trim_q;
    del_d      = del_q;
    handle_d   = handle_q;
    delay_d    = delay_q;
    period_d   = period_q;
    tid_d      = tid_q;
    run_d      = run_q;
    redo_d     = redo_q;
    fin        = 1'b0;
    fin_status = dlts_pkg::ST_OK;
    fin_rid    = '0;
    req        = '0;
    req.wdata  = ram_rdata_i;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          handle_d = cmd_i.task_handle;
          delay_d  = cmd_i.delay;
          period_d = cmd_i.period;
          tid_d    = cmd_i.task_id;
          run_d    = '0;
          redo_d   = 1'b0;
          idx_d    = '0;
          sum_d    = '0;
          case (cmd_i.func)
            dlts_pkg::FN_TICK: begin
              if (cnt_q != '0 && !head_rdy_q) begin
                req.re  = 1'b1;
                state_d = S_TICK;
              end else begin
                fin = 1'b1;
              end
            end
            dlts_pkg::FN_ADD: begin
              if (cnt_q == dlts_pkg::CNT_W'(dlts_pkg::QUEUE_DEPTH)) begin
                fin        = 1'b1;
                fin_status = dlts_pkg::ST_FULL;
              end else begin
                state_d = S_ADD_RD;
              end
            end
            dlts_pkg::FN_DELETE: begin
              state_d = S_DEL_RD;
            end
            default: begin
              if (cnt_q != '0 && head_rdy_q) begin
                req.re  = 1'b1;
                state_d = S_DSP;
              end else begin
                fin        = 1'b1;
                fin_status = dlts_pkg::ST_NONE;
              end
            end
          endcase
        end
      end
      S_TICK: begin
        req.we          = 1'b1;
        req.wdata.delta = dec;
        req.wdata.ready = (dec == '0);
        fin             = 1'b1;
      end
      S_ADD_RD: begin
        if (idx_q == cnt_q) begin
          ins_d   = idx_q[dlts_pkg::IDX_W-1:0];
          state_d = S_ADD_WR;
        end else begin
          req.re    = 1'b1;
          req.raddr = idx_q[dlts_pkg::IDX_W-1:0];
          state_d   = S_ADD_CHK;
        end
      end
      S_ADD_CHK: begin
        if (tot > {1'b0, delay_q}) begin
          ins_d   = idx_q[dlts_pkg::IDX_W-1:0];
          trim_d  = 32'(tot - {1'b0, delay_q});
          idx_d   = cnt_q;
          state_d = S_SUP_RD;
        end else begin
          sum_d   = tot[31:0];
          idx_d   = idx_q + 1'b1;
          state_d = S_ADD_RD;
        end
      end
      S_SUP_RD: begin
        if (idx_q[dlts_pkg::IDX_W-1:0] == ins_q) begin
          state_d = S_ADD_WR;
        end else begin
          req.re    = 1'b1;
          req.raddr = idx_q[dlts_pkg::IDX_W-1:0] - 1'b1;
          state_d   = S_SUP_WR;
        end
      end
      S_SUP_WR: begin
        req.we    = 1'b1;
        req.waddr = idx_q[dlts_pkg::IDX_W-1:0];
        if (idx_q[dlts_pkg::IDX_W-1:0] - 1'b1 == ins_q) begin
          req.wdata.delta = trim_q;
        end
        idx_d   = idx_q - 1'b1;
        state_d = S_SUP_RD;
      end
      S_ADD_WR: begin
        req.we    = 1'b1;
        req.waddr = ins_q;
        req.wdata = '{handle: handle_q, delta: nd, period: period_q,
                      ident: fresh, ready: (nd == '0)};
        nid_d     = fresh;
        cnt_d     = cnt_q + 1'b1;
        fin       = 1'b1;
        fin_rid   = fresh;
      end
      S_DEL_RD: begin
        if (idx_q == cnt_q) begin
          fin        = 1'b1;
          fin_status = dlts_pkg::ST_NONE;
        end else begin
          req.re    = 1'b1;
          req.raddr = idx_q[dlts_pkg::IDX_W-1:0];
          state_d   = S_DEL_CHK;
        end
      end
      S_DEL_CHK: begin
        if (tid_q != '0 && ram_rdata_i.ident == tid_q) begin
          del_d   = ram_rdata_i.delta;
          ins_d   = idx_q[dlts_pkg::IDX_W-1:0];
          state_d = S_SDN_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_DEL_RD;
        end
      end
      S_DSP: begin
        run_d    = ram_rdata_i.handle;
        handle_d = ram_rdata_i.handle;
        delay_d  = ram_rdata_i.period;
        period_d = ram_rdata_i.period;
        del_d    = ram_rdata_i.delta;
        ins_d    = '0;
        idx_d    = '0;
        redo_d   = 1'b1;
        state_d  = S_SDN_RD;
      end
      S_SDN_RD: begin
        if (idx_q + 1'b1 == cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          if (redo_q && period_q != '0) begin
            idx_d   = '0;
            sum_d   = '0;
            state_d = S_ADD_RD;
          end else begin
            fin = 1'b1;
          end
        end else begin
          req.re    = 1'b1;
          req.raddr = idx_q[dlts_pkg::IDX_W-1:0] + 1'b1;
          state_d   = S_SDN_WR;
        end
      end
      S_SDN_WR: begin
        req.we    = 1'b1;
        req.waddr = idx_q[dlts_pkg::IDX_W-1:0];
        if (idx_q[dlts_pkg::IDX_W-1:0] == ins_q) begin
          req.wdata.delta = fold_sat;
          req.wdata.ready = ram_rdata_i.ready && (fold_sat == '0);
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_SDN_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // head ready flag mirrors every write to the head slot
    if (req.we && req.waddr == '0) begin
      head_rdy_d = req.wdata.ready;
    end

    if (fin) begin
      state_d = S_IDLE;
      done_d  = 1'b1;
      res_d   = '{status: fin_status, result_id: fin_rid, run_handle: run_d,
                  head_ready: (cnt_d != '0) && head_rdy_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      head_rdy_q <= 1'b0;
      nid_q      <= '0;
      done_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      head_rdy_q <= head_rdy_d;
      nid_q      <= nid_d;
      done_q     <= done_d;
      res_q      <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    ins_q    <= ins_d;
    sum_q    <= sum_d;
    trim_q   <= trim_d;
    del_q    <= del_d;
    handle_q <= handle_d;
    delay_q  <= delay_d;
    period_q <= period_d;
    tid_q    <= tid_d;
    run_q    <= run_d;
    redo_q   <= redo_d;
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = done_q;
  assign res_o       = res_q;
  assign ram_req_o   = req;

endmodule

// File: rtl/delta_list_timer_scheduler.sv
// top level of the delta-list timer scheduler
// usage:
// - an item (func, task_handle, delay, period, task_id on cmd_i) is taken at a rising
//   edge with start high and busy low; busy is never low while an item is in work
// - func selects tick, add, delete by id or dispatch of a ready head
// - each item gives one result on res_o, marked by done_o for exactly one cycle;
//   the receiver cannot stall, so the result must be taken in that cycle
// - busy drops in the cycle done_o rises, so the next item may follow at once
// - the entry ram is reached through a single read port and a single write port
//   tick: counts the head down when there is one that is not yet ready
//   add: walks the entries, shifts the later ones up and writes the new entry
//   delete: searches for the id, then shifts the later entries down
//   dispatch: removes a ready head by shifting the entries down, then adds it again
//   over the entries left when the task is periodic
// - the fill count and head flag clear at reset, so the queue starts empty; the
//   entry ram needs no clearing pass and an item may be given right after reset
`timescale 1ns / 1ps
module delta_list_timer_scheduler (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  dlts_pkg::cmd_t  cmd_i,
  output logic            done_o,
  output dlts_pkg::res_t  res_o
);

  dlts_pkg::stat_t    stat;
  dlts_pkg::ram_req_t ram_req;
  dlts_pkg::entry_t   ram_rdata;

  dlts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .stat_o      (stat),
    .res_o       (res_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  dlts_ram #(
    .DEPTH (dlts_pkg::QUEUE_DEPTH),
    .WIDTH (dlts_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign busy   = stat.busy;
  assign done_o = stat.done;

endmodule

// File: rtl/dlts_checker.sv
// port-level checks of the delta-list timer scheduler and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dlts_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_i,
  input logic           done_i,
  input dlts_pkg::res_t res_i
);

  logic fail_res;
  logic clean_res;

  assign fail_res  = done_i && (res_i.status != dlts_pkg::ST_OK);
  assign clean_res = (res_i.result_id == '0) && (res_i.run_handle == '0);

  `DLTS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_i, !busy_i)
  `DLTS_ASSERT_IMP(a_status_code, clk_i, rst_ni, done_i, res_i.status <= dlts_pkg::ST_FULL)
  `DLTS_ASSERT_IMP(a_fail_clean, clk_i, rst_ni, fail_res, clean_res)
  `DLTS_ASSERT_NEXT(a_accept_runs, clk_i, rst_ni, start_i && !busy_i, busy_i || done_i)

endmodule

bind delta_list_timer_scheduler dlts_checker u_dlts_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .done_i  (done_o),
  .res_i   (res_o)
);
